/* hdl/kss_pkg.sv */
`timescale 1ns / 1ps

package kss_pkg;

    // default sizing, handed down from the top level
    localparam int NUM_STACKS_DEF = 4;
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed port widths
    localparam int SEL_W    = 2;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status codes
    localparam t_status STATUS_DONE  = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

endpackage

/* hdl/kss_ram.sv */
`timescale 1ns / 1ps

// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data. Contents are not reset.
module kss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/k_stacks_shared_store.sv */
`timescale 1ns / 1ps
// Result: the operation is registered on acceptance, and its result word is registered as it leaves S_EXEC.
// Issue: a new operation is accepted only once the previous one has left S_EXEC,
//   after the link memory read and the pointer write-back of that operation.
// Reset: synchronous, active low; all stacks empty, free list back to slots 0..DEPTH-1
//   at once through a fill mark, no clearing pass; the data store is not cleared.
module k_stacks_shared_store #(
    parameter int NUM_STACKS = kss_pkg::NUM_STACKS_DEF,
    parameter int DEPTH      = kss_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = kss_pkg::DATA_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_op,
    input  logic [kss_pkg::SEL_W-1:0]          i_stack_sel,
    input  logic signed [kss_pkg::VAL_W-1:0]   i_push_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [kss_pkg::VAL_W-1:0]   o_pop_value,
    output logic [kss_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_stack_empty,
    output logic                               o_store_full
);

    import kss_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW   = AW + 1;                       // link: valid bit + slot index
    localparam int SW   = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int ExtW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
    localparam logic [AW:0] DepthW = LW'(DEPTH);

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state                r_state;
    logic                  r_op;
    logic                  r_bad;
    logic [SW-1:0]         r_sel;
    logic [AW-1:0]         r_addr;

    // stack tops and free list head
    logic [NUM_STACKS-1:0] r_top_vld;
    logic [AW-1:0]         r_top_idx [NUM_STACKS];
    logic                  r_free_vld;
    logic [AW-1:0]         r_free_idx;
    logic [AW:0]           r_hwm;                       // slots ever handed out

    // output register
    logic                  r_out_valid;
    logic [VAL_W-1:0]      r_pop_value;
    t_status               r_status;
    logic                  r_stack_empty;
    logic                  r_store_full;

    logic                  w_accept;
    logic                  w_go;
    logic                  w_sel_ok;
    logic [SW-1:0]         w_sel;
    logic [AW-1:0]         w_rd_addr;
    logic [ExtW-1:0]       w_val_ext;
    logic [ExtW-1:0]       w_rd_ext;
    logic [LW-1:0]         w_link_rd;
    logic [DATA_WIDTH-1:0] w_data_rd;
    logic                  w_fresh;
    logic                  w_cur_vld;
    logic [AW-1:0]         w_cur_idx;

    logic                  n_top_we;
    logic                  n_top_vld;
    logic [AW-1:0]         n_top_idx;
    logic                  n_free_vld;
    logic [AW-1:0]         n_free_idx;
    logic [AW:0]           n_hwm;
    logic                  n_link_we;
    logic [LW-1:0]         n_link_wdata;
    logic [VAL_W-1:0]      n_pop_value;
    t_status               n_status;
    logic                  n_stack_empty;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid & o_in_ready;
    assign w_go       = (r_state == S_EXEC) & (~r_out_valid | i_out_ready);

    // accept side: pick the slot whose link is needed
    assign w_sel_ok  = (int'(i_stack_sel) < NUM_STACKS);
    assign w_sel     = w_sel_ok ? SW'(i_stack_sel) : '0;
    assign w_rd_addr = (i_op == OP_PUSH) ? r_free_idx : r_top_idx[w_sel];
    assign w_val_ext = ExtW'(i_push_value);
    assign w_rd_ext  = ExtW'(w_data_rd);

    // link store: next slot of a stack or of the free list
    kss_ram #(
        .WIDTH (LW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (n_link_we),
        .i_waddr (r_addr),
        .i_wdata (n_link_wdata),
        .i_re    (w_accept),
        .i_raddr (w_rd_addr),
        .o_rdata (w_link_rd)
    );

    // data store: written straight away when a push is known to succeed
    kss_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept & (i_op == OP_PUSH) & w_sel_ok & r_free_vld),
        .i_waddr (r_free_idx),
        .i_wdata (w_val_ext[DATA_WIDTH-1:0]),
        .i_re    (w_accept & (i_op == OP_POP)),
        .i_raddr (w_rd_addr),
        .o_rdata (w_data_rd)
    );

    // slots at or above the fill mark were never linked: they chain in order
    assign w_fresh   = (LW'(r_free_idx) == r_hwm);
    assign w_cur_vld = r_top_vld[r_sel];
    assign w_cur_idx = r_top_idx[r_sel];

    // execute: pointer update and result
    always_comb begin
        n_top_we      = 1'b0;
        n_top_vld     = 1'b0;
        n_top_idx     = '0;
        n_free_vld    = r_free_vld;
        n_free_idx    = r_free_idx;
        n_hwm         = r_hwm;
        n_link_we     = 1'b0;
        n_link_wdata  = '0;
        n_pop_value   = '0;
        n_status      = STATUS_DONE;
        n_stack_empty = 1'b0;
        if (r_bad) begin
            n_status      = (r_op == OP_PUSH) ? STATUS_FULL : STATUS_EMPTY;
            n_stack_empty = 1'b1;
        end else if (r_op == OP_PUSH) begin
            if (!r_free_vld) begin
                n_status      = STATUS_FULL;
                n_stack_empty = ~w_cur_vld;
            end else begin
                n_link_we    = w_go;
                n_link_wdata = {w_cur_vld, w_cur_idx};
                n_top_we     = 1'b1;
                n_top_vld    = 1'b1;
                n_top_idx    = r_addr;
                if (w_fresh) begin
                    n_hwm      = r_hwm + LW'(1);
                    n_free_vld = ((r_hwm + LW'(1)) < DepthW);
                    n_free_idx = r_free_idx + AW'(1);
                end else begin
                    n_free_vld = w_link_rd[AW];
                    n_free_idx = w_link_rd[AW-1:0];
                end
            end
        end else begin
            if (!w_cur_vld) begin
                n_status      = STATUS_EMPTY;
                n_stack_empty = 1'b1;
            end else begin
                n_top_we      = 1'b1;
                n_top_vld     = w_link_rd[AW];
                n_top_idx     = w_link_rd[AW-1:0];
                n_link_we     = w_go;
                n_link_wdata  = {r_free_vld, r_free_idx};
                n_free_vld    = 1'b1;
                n_free_idx    = r_addr;
                n_pop_value   = w_rd_ext[VAL_W-1:0];
                n_stack_empty = ~w_link_rd[AW];
            end
        end
    end

    // state, pointers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_top_vld   <= '0;
            r_free_vld  <= 1'b1;
            r_free_idx  <= '0;
            r_hwm       <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_go) begin
                r_out_valid <= 1'b1;
                r_free_vld  <= n_free_vld;
                r_free_idx  <= n_free_idx;
                r_hwm       <= n_hwm;
                if (n_top_we) begin
                    r_top_vld[r_sel] <= n_top_vld;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        // payload, no reset
        if (w_accept) begin
            r_op   <= i_op;
            r_bad  <= ~w_sel_ok;
            r_sel  <= w_sel;
            r_addr <= w_rd_addr;
        end
        if (w_go) begin
            r_pop_value   <= n_pop_value;
            r_status      <= n_status;
            r_stack_empty <= n_stack_empty;
            r_store_full  <= ~n_free_vld;
            if (n_top_we) begin
                r_top_idx[r_sel] <= n_top_idx;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pop_value   = r_pop_value;
    assign o_status      = r_status;
    assign o_stack_empty = r_stack_empty;
    assign o_store_full  = r_store_full;

endmodule

/* hdl/kss_checker.sv */
`timescale 1ns / 1ps

module kss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [kss_pkg::VAL_W-1:0]   o_pop_value,
    input logic [kss_pkg::STATUS_W-1:0]       o_status,
    input logic                               o_stack_empty,
    input logic                               o_store_full
);

    import kss_pkg::*;

    logic [1:0] r_cnt;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid & o_in_ready;
    assign w_out_acc = o_out_valid & i_out_ready;

    // words accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(w_in_acc) - 2'(w_out_acc);
        end
    end

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pop_value)
            && $stable(o_status) && $stable(o_stack_empty) && $stable(o_store_full))
        else $error("result word changed while stalled");

    // no result without an outstanding word, and at most two in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != 2'd0)
        else $error("result word with no accepted input");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_in_ready)
        else $error("input taken while two words outstanding");

    // failed operations return zero, a failed pop reports the stack empty
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_DONE |-> o_pop_value == '0)
        else $error("non-zero value on failed operation");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STATUS_EMPTY |-> o_stack_empty)
        else $error("empty status without empty flag");

endmodule

bind k_stacks_shared_store kss_checker u_kss_checker (.*);
